@@ design/bld_pkg.sv @@
package bld_pkg;

  localparam int FracBits = 28;
  localparam int IterLimit = 32;

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_K1 = 3'd0,
    REG_K2 = 3'd1,
    REG_K3 = 3'd2,
    REG_T1 = 3'd3,
    REG_T2 = 3'd4,
    REG_TOL = 3'd5,
    REG_MAXIT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
  } coef_t;

  function automatic logic [32:0] sat64(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > QMax) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < QMin) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

@@ design/brown_lens_distortion.sv @@
// Brown lens distortion with three radial and two tangential terms, Q3.28.
// Input channel: in_valid/in_ready with in_cmd (0 apply, 1 remove), in_x_in,
// in_y_in. Result channel: out_valid/out_ready with the point, converged,
// iterations_used and overflow flags.
// Configuration: APB-style port, registers at byte address 4*i; the user must
// write them only while the block is idle, which the block does not enforce.
// One distortion evaluation runs 14 products through the shared multiplier.
// Apply raises out_valid after one evaluation. Remove checks the residual
// after each evaluation and raises out_valid after at most 32 updates.
// in_ready rises in the cycle after the result is taken, so a new request
// is accepted only after the previous result has been taken.
// The block accepts a request only when idle with its output register empty;
// a stalled receiver holds the result in the output register and holds off
// the next request.
// Reset clears the sequencer, empties the output register and restores the
// register defaults: all coefficients 0, tolerance 1, max_iterations 16.
module brown_lens_distortion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic               out_converged,
  output logic [5:0]         out_iterations_used,
  output logic               out_overflow,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WAIT, S_ADD, S_RES, S_UPD, S_DONE
  } state_t;

  bld_pkg::coef_t coef_r;
  logic [15:0] tol_r;
  logic [5:0] maxit_r;

  state_t state_r;
  logic cmd_r;
  logic signed [31:0] px_r, py_r, rx_r, ry_r;
  logic signed [31:0] xx_r, yy_r, xy_r, r2_r, r4_r, r6_r, kd_r, tx_r, ty_r, dx_r, dy_r;
  logic signed [31:0] m1_r, m2_r, m3_r, a2_r, b2_r;
  logic [3:0] step_r;
  logic [5:0] iters_r;
  logic ovf_r;
  logic signed [31:0] ma, mb, mp;
  logic m_ovf;

  logic [2:0] widx;
  assign widx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    unique case (widx)
      bld_pkg::REG_K1: cfg_prdata = coef_r.k1;
      bld_pkg::REG_K2: cfg_prdata = coef_r.k2;
      bld_pkg::REG_K3: cfg_prdata = coef_r.k3;
      bld_pkg::REG_T1: cfg_prdata = coef_r.t1;
      bld_pkg::REG_T2: cfg_prdata = coef_r.t2;
      bld_pkg::REG_TOL: cfg_prdata = {16'd0, tol_r};
      bld_pkg::REG_MAXIT: cfg_prdata = {26'd0, maxit_r};
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      tol_r <= 16'd1;
      maxit_r <= 6'd16;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (widx)
        bld_pkg::REG_K1: coef_r.k1 <= cfg_pwdata;
        bld_pkg::REG_K2: coef_r.k2 <= cfg_pwdata;
        bld_pkg::REG_K3: coef_r.k3 <= cfg_pwdata;
        bld_pkg::REG_T1: coef_r.t1 <= cfg_pwdata;
        bld_pkg::REG_T2: coef_r.t2 <= cfg_pwdata;
        bld_pkg::REG_TOL: tol_r <= cfg_pwdata[15:0];
        bld_pkg::REG_MAXIT: maxit_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // multiply sequence per evaluation
  always_comb begin
    ma = rx_r;
    mb = rx_r;
    unique case (step_r)
      4'd0: begin ma = rx_r; mb = rx_r; end
      4'd1: begin ma = ry_r; mb = ry_r; end
      4'd2: begin ma = rx_r; mb = ry_r; end
      4'd3: begin ma = r2_r; mb = r2_r; end
      4'd4: begin ma = r4_r; mb = r2_r; end
      4'd5: begin ma = coef_r.k1; mb = r2_r; end
      4'd6: begin ma = coef_r.k2; mb = r4_r; end
      4'd7: begin ma = coef_r.k3; mb = r6_r; end
      4'd8: begin ma = coef_r.t2; mb = a2_r; end
      4'd9: begin ma = coef_r.t1; mb = xy_r; end
      4'd10: begin ma = coef_r.t1; mb = b2_r; end
      4'd11: begin ma = coef_r.t2; mb = xy_r; end
      4'd12: begin ma = rx_r; mb = kd_r; end
      4'd13: begin ma = ry_r; mb = kd_r; end
      default: begin ma = rx_r; mb = rx_r; end
    endcase
  end

  bld_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp), .p_ovf(m_ovf));

  logic [32:0] s_a, s_b, s_c, s_d;
  logic [32:0] acc;
  logic signed [63:0] resid;
  logic signed [63:0] ex, ey;
  logic [5:0] limit;

  always_comb begin
    ex = 64'(rx_r) + 64'(dx_r) - 64'(px_r);
    ey = 64'(ry_r) + 64'(dy_r) - 64'(py_r);
    resid = (ex < 0 ? -ex : ex) + (ey < 0 ? -ey : ey);
    limit = (maxit_r < 6'(bld_pkg::IterLimit)) ? maxit_r : 6'(bld_pkg::IterLimit);
    s_a = bld_pkg::sat64(64'(px_r) - 64'(dx_r));
    s_b = bld_pkg::sat64(64'(py_r) - 64'(dy_r));
    s_c = bld_pkg::sat64(64'(rx_r) + 64'(dx_r));
    s_d = bld_pkg::sat64(64'(ry_r) + 64'(dy_r));
  end

  // saturated sum for the current step
  always_comb begin
    acc = '0;
    unique case (step_r)
      4'd2: acc = bld_pkg::sat64(64'(xx_r) + 64'(yy_r));
      4'd3: acc = bld_pkg::sat64(64'(r2_r) + 64'(xx_r) + 64'(xx_r));
      4'd4: acc = bld_pkg::sat64(64'(r2_r) + 64'(yy_r) + 64'(yy_r));
      4'd7: acc = bld_pkg::sat64(64'(m1_r) + 64'(m2_r) + 64'(mp));
      4'd9, 4'd11: acc = bld_pkg::sat64(64'(m3_r) + 64'(mp) + 64'(mp));
      4'd12: acc = bld_pkg::sat64(64'(mp) + 64'(tx_r));
      4'd13: acc = bld_pkg::sat64(64'(mp) + 64'(ty_r));
      default: acc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      step_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_cmd;
            px_r <= in_x_in;
            py_r <= in_y_in;
            rx_r <= in_x_in;
            ry_r <= in_y_in;
            iters_r <= '0;
            ovf_r <= 1'b0;
            step_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_WAIT;
        S_WAIT: begin
          ovf_r <= ovf_r | m_ovf | acc[32];
          state_r <= (step_r == 4'd13) ? S_ADD : S_MUL;
          step_r <= step_r + 4'd1;
          unique case (step_r)
            4'd0: xx_r <= mp;
            4'd1: yy_r <= mp;
            4'd2: begin
              xy_r <= mp;
              r2_r <= acc[31:0];
            end
            4'd3: begin
              r4_r <= mp;
              a2_r <= acc[31:0];
            end
            4'd4: begin
              r6_r <= mp;
              b2_r <= acc[31:0];
            end
            4'd5: m1_r <= mp;
            4'd6: m2_r <= mp;
            4'd7: kd_r <= acc[31:0];
            4'd8: m3_r <= mp;
            4'd9: tx_r <= acc[31:0];
            4'd10: m3_r <= mp;
            4'd11: ty_r <= acc[31:0];
            4'd12: dx_r <= acc[31:0];
            4'd13: dy_r <= acc[31:0];
            default: ;
          endcase
        end
        S_ADD: begin
          step_r <= '0;
          if (!cmd_r) begin
            out_x_out <= s_c[31:0];
            out_y_out <= s_d[31:0];
            out_converged <= 1'b1;
            out_iterations_used <= '0;
            out_overflow <= ovf_r | s_c[32] | s_d[32];
            out_valid <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (resid <= 64'(tol_r) || iters_r >= limit) begin
            out_x_out <= rx_r;
            out_y_out <= ry_r;
            out_converged <= (resid <= 64'(tol_r));
            out_iterations_used <= iters_r;
            out_overflow <= ovf_r;
            out_valid <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          rx_r <= s_a[31:0];
          ry_r <= s_b[31:0];
          ovf_r <= ovf_r | s_a[32] | s_b[32];
          iters_r <= iters_r + 6'd1;
          state_r <= S_MUL;
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ design/bld_mul.sv @@
module bld_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] p,
  output logic               p_ovf
);

  logic signed [63:0] prod;
  logic signed [63:0] shifted;
  logic [32:0] s;

  always_comb begin
    prod = a * b;
    shifted = (prod + (64'sd1 <<< (bld_pkg::FracBits - 1))) >>> bld_pkg::FracBits;
    s = bld_pkg::sat64(shifted);
  end

  always_ff @(posedge clk) begin
    p <= s[31:0];
    p_ovf <= s[32];
  end

endmodule
